// ===== rtl/lfsq_pkg.sv =====
// ----------------------------------------------------------------------------
// lfsq_pkg: shared constants for the largest free square finder
// Grid limits, field widths, value limit, count reset values and config register indexes.
// ----------------------------------------------------------------------------
package lfsq_pkg;

  // Default grid limits.
  localparam int unsigned MaxColumnsDefault = 1024;
  localparam int unsigned MaxRowsDefault    = 1024;

  // Field widths.
  localparam int unsigned ValueW   = 11;
  localparam int unsigned CountW   = 11;
  localparam int unsigned OutRowW  = 10;
  localparam int unsigned OutColW  = 10;
  localparam int unsigned CfgIdxW  = 1;

  // Saturation limit of a cell value.
  localparam logic [ValueW-1:0] ValueMax = '1;

  // Reset values of the count registers.
  localparam logic [CountW-1:0] CountReset = 11'd1024;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgRowCount    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgColumnCount = 1'b1;

endpackage

// ===== rtl/largest_free_square_finder.sv =====
// The last cell of a grid passes stage 1; its result is caught in the output register.
// Throughput: one cell per cycle when not stalled; the line buffer is read a cell ahead
// and written back from stage 1, with a bypass when both touch the same column.
// A grid result that waits on the output stalls the input only if a further grid ends.
// Reset clears counters, best tracking and handshake state; the line buffer is not
// cleared, since row 0 ignores it and writes every entry that later rows read.
// ----------------------------------------------------------------------------
// largest_free_square_finder
// Streams a binary grid in row-major order with a one-row buffer and reports the side
// and bottom-right corner of the largest all-free square; below two it gives 1 at (0,0).
// ----------------------------------------------------------------------------
module largest_free_square_finder #(
  parameter int unsigned MAX_COLUMNS = lfsq_pkg::MaxColumnsDefault,
  parameter int unsigned MAX_ROWS    = lfsq_pkg::MaxRowsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lfsq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lfsq_pkg::CountW-1:0]   cfg_data_i,
  // Cell items
  input  logic                          cell_valid_i,
  output logic                          cell_stall_o,
  input  logic                          cell_free_i,
  // Result items
  output logic                          res_valid_o,
  input  logic                          res_stall_i,
  output logic [lfsq_pkg::ValueW-1:0]   best_size_o,
  output logic [lfsq_pkg::OutRowW-1:0]  best_row_o,
  output logic [lfsq_pkg::OutColW-1:0]  best_column_o
);

  localparam int unsigned ColW  = $clog2(MAX_COLUMNS);
  localparam int unsigned RowW  = $clog2(MAX_ROWS);
  localparam int unsigned ColCW = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned RowCW = $clog2(MAX_ROWS + 1);
  localparam int unsigned VW    = lfsq_pkg::ValueW;

  // Configuration registers.
  logic [lfsq_pkg::CountW-1:0] row_count_q, col_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= lfsq_pkg::CountReset;
      col_count_q <= lfsq_pkg::CountReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lfsq_pkg::CfgRowCount:    row_count_q <= cfg_data_i;
        lfsq_pkg::CfgColumnCount: col_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective counts: zero acts as one, values above the limits clamp.
  logic [31:0]      rows_wide, cols_wide;
  logic [RowCW-1:0] rows_eff;
  logic [ColCW-1:0] cols_eff;

  always_comb begin
    rows_wide = 32'(row_count_q);
    cols_wide = 32'(col_count_q);
    if (rows_wide == 32'd0) begin
      rows_wide = 32'd1;
    end else if (rows_wide > 32'(MAX_ROWS)) begin
      rows_wide = 32'(MAX_ROWS);
    end
    if (cols_wide == 32'd0) begin
      cols_wide = 32'd1;
    end else if (cols_wide > 32'(MAX_COLUMNS)) begin
      cols_wide = 32'(MAX_COLUMNS);
    end
    rows_eff = RowCW'(rows_wide);
    cols_eff = ColCW'(cols_wide);
  end

  // Stage 1 registers and handshake.
  logic          s1_valid_q, s1_cell_q, s1_row0_q, s1_edge_q, s1_wrap_q, s1_last_q;
  logic [ColW-1:0] s1_col_q;
  logic [RowW-1:0] s1_row_q;
  logic          fwd_hit_q;
  logic [VW-1:0] fwd_val_q;
  logic          s1_go, cell_accept, res_valid_q;

  assign s1_go        = !s1_valid_q || !s1_last_q || !res_valid_q || !res_stall_i;
  assign cell_stall_o = !s1_go;
  assign cell_accept  = cell_valid_i && s1_go;

  // Position counters; the next position depends only on the current one and the counts.
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic            col_more, row_more;

  assign col_more = (ColCW'(col_q) + ColCW'(1)) < cols_eff;
  assign row_more = (RowCW'(row_q) + RowCW'(1)) < rows_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cell_accept) begin
      if (col_more) begin
        col_q <= col_q + ColW'(1);
      end else if (row_more) begin
        col_q <= '0;
        row_q <= row_q + RowW'(1);
      end else begin
        col_q <= '0;
        row_q <= '0;
      end
    end
  end

  // Stage 1: minimum of neighbors plus one, saturating, for free cells off the edges.
  logic [VW-1:0] left_q, diag_q, up_raw, up_val, min_val, value;
  logic [VW-1:0] rdata_q;

  assign up_raw = fwd_hit_q ? fwd_val_q : rdata_q;
  assign up_val = s1_row0_q ? '0 : up_raw;

  always_comb begin
    min_val = up_val;
    if (diag_q < min_val) min_val = diag_q;
    if (left_q < min_val) min_val = left_q;
    if (s1_edge_q) begin
      value = VW'(s1_cell_q);
    end else if (!s1_cell_q) begin
      value = '0;
    end else if (min_val == lfsq_pkg::ValueMax) begin
      value = lfsq_pkg::ValueMax;
    end else begin
      value = min_val + VW'(1);
    end
  end

  logic s1_fire;
  assign s1_fire = s1_valid_q && s1_go;

  // Line buffer: read one cell ahead, written back from stage 1.
  logic [VW-1:0] line_mem [MAX_COLUMNS];

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      line_mem[s1_col_q] <= value;
    end
    if (cell_accept) begin
      rdata_q <= line_mem[col_q];
    end
  end

  // Stage 1 payload and bypass of the write that overlaps the read.
  always_ff @(posedge clk_i) begin
    if (cell_accept) begin
      s1_cell_q <= cell_free_i;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_row0_q <= (row_q == '0);
      s1_edge_q <= (row_q == '0) || (col_q == '0);
      s1_wrap_q <= !col_more;
      s1_last_q <= !col_more && !row_more;
      fwd_hit_q <= s1_valid_q && (s1_col_q == col_q);
      fwd_val_q <= value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_go) begin
      s1_valid_q <= cell_valid_i;
    end
  end

  // Best tracking and neighbor registers.
  logic [VW-1:0]   best_size_q, best_size_d;
  logic [RowW-1:0] best_row_q, best_row_d;
  logic [ColW-1:0] best_col_q, best_col_d;

  always_comb begin
    best_size_d = best_size_q;
    best_row_d  = best_row_q;
    best_col_d  = best_col_q;
    if (value > best_size_q) begin
      best_size_d = value;
      best_row_d  = s1_row_q;
      best_col_d  = s1_col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      diag_q      <= '0;
      best_size_q <= VW'(1);
      best_row_q  <= '0;
      best_col_q  <= '0;
    end else if (s1_fire) begin
      if (s1_wrap_q) begin
        left_q <= '0;
        diag_q <= '0;
      end else begin
        left_q <= value;
        diag_q <= up_val;
      end
      if (s1_last_q) begin
        best_size_q <= VW'(1);
        best_row_q  <= '0;
        best_col_q  <= '0;
      end else begin
        best_size_q <= best_size_d;
        best_row_q  <= best_row_d;
        best_col_q  <= best_col_d;
      end
    end
  end

  // Output register.
  logic [VW-1:0]                 out_size_q;
  logic [lfsq_pkg::OutRowW-1:0]  out_row_q;
  logic [lfsq_pkg::OutColW-1:0]  out_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_fire && s1_last_q) begin
      res_valid_q <= 1'b1;
    end else if (!res_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      out_size_q <= best_size_d;
      out_row_q  <= lfsq_pkg::OutRowW'(best_row_d);
      out_col_q  <= lfsq_pkg::OutColW'(best_col_d);
    end
  end

  assign res_valid_o   = res_valid_q;
  assign best_size_o   = out_size_q;
  assign best_row_o    = out_row_q;
  assign best_column_o = out_col_q;

  // A result appears only after the last cell of a grid left stage 1.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(s1_valid_q && s1_last_q))
    else $error("result raised without a finished grid");

  // The input stalls only behind a grid end waiting on a blocked result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_stall_o |-> (s1_valid_q && s1_last_q && res_valid_q))
    else $error("input stalled without a blocked grid end");

  // The best size never drops below one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_size_q != '0)
    else $error("best size held at zero");

  // The bypass is armed only when the read column matches the written one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_accept && s1_valid_q && (s1_col_q != col_q)) |=> !fwd_hit_q)
    else $error("bypass armed for a different column");

endmodule
